[hdl/spisfx_pkg.sv]
// Package for the SPI slave frame sync exchange block: frame layout constants,
// command and event codes, and the decoded item passed from front to back.
// No dependencies.
`default_nettype none

package spisfx_pkg;

    localparam int FRAME_LEN  = 8;
    localparam int CODE_LEN   = 3;
    localparam int SERVO_SLOT = 3;
    localparam int FPOS_W     = $clog2(FRAME_LEN);
    localparam int POS_W      = 3;

    localparam logic [7:0] FILL_RESET  = 8'hBE;
    localparam logic [7:0] SERVO_RESET = 8'd125;
    localparam logic [7:0] CODE_R      = 8'h52;
    localparam logic [7:0] CODE_O      = 8'h4F;
    localparam logic [7:0] CODE_B      = 8'h42;

    typedef logic [7:0] byte_t;
    typedef byte_t frame_t [FRAME_LEN];

    typedef enum logic [1:0] {
        CMD_EXCHANGE = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_READ     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_EXCHANGE,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_SYNCED   = 3'd1,
        EV_ACCEPTED = 3'd2,
        EV_CODE_ERR = 3'd3,
        EV_SUM_ERR  = 3'd4
    } event_t;

    typedef struct packed {
        op_t                op;
        logic [7:0]         rx_byte;
        logic [POS_W-1:0]   byte_position;
        logic [7:0]         payload_value;
    } item_t;

    function automatic byte_t code_byte(input int k);
        byte_t b;
        case (k)
            0:       b = CODE_R;
            1:       b = CODE_O;
            default: b = CODE_B;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hdl/spisfx_front.sv]
// Front end: accepts input transfers and classifies each command into an op,
// dropping writes outside the payload and unknown commands to a no-op. Uses spisfx_pkg.
`default_nettype none

module spisfx_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // rx_byte, byte_position, payload_value
    input  wire logic [1:0]           s_tuser,   // command
    input  wire logic                 q_full,
    output logic                      q_push,
    output spisfx_pkg::item_t         q_item
);
    import spisfx_pkg::*;

    logic [POS_W-1:0] pos;
    logic             wr_ok;
    logic             rd_ok;

    assign pos      = s_tdata[10:8];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // writes only land in the payload; code bytes and checksum are protected
    assign wr_ok = (int'(pos) >= CODE_LEN) && (int'(pos) < FRAME_LEN - 1);
    assign rd_ok = int'(pos) < FRAME_LEN;

    always_comb
    begin
        q_item.rx_byte       = s_tdata[7:0];
        q_item.byte_position = pos;
        q_item.payload_value = s_tdata[18:11];
        case (s_tuser)
            CMD_EXCHANGE: q_item.op = OP_EXCHANGE;
            CMD_WRITE:    q_item.op = wr_ok ? OP_WRITE : OP_NOP;
            CMD_READ:     q_item.op = rd_ok ? OP_READ : OP_NOP;
            default:      q_item.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

[hdl/spisfx_queue.sv]
// Two-entry queue of decoded items between front and back end.
// Uses spisfx_pkg for the item type.
`default_nettype none

module spisfx_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  spisfx_pkg::item_t       push_item,
    output logic                    full,
    input  wire logic               pop,
    output spisfx_pkg::item_t       head_item,
    output logic                    empty
);
    import spisfx_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign empty     = count_reg == 2'd0;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

[hdl/spisfx_back.sv]
// Back end: frame state (receive window, outgoing frames, latched frame, sync), executes
// one decoded item per cycle into the output register when not stalled. Uses spisfx_pkg.
`default_nettype none

module spisfx_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [7:0]         cfg_data,
    input  spisfx_pkg::item_t       head_item,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata    // tx_byte, frame_event, link_synced, read_data
);
    import spisfx_pkg::*;

    byte_t             fill_reg;
    frame_t            window_reg;
    frame_t            window_next;
    frame_t            active_reg;
    frame_t            active_next;
    frame_t            staged_reg;
    frame_t            staged_next;
    frame_t            latched_reg;
    frame_t            latched_next;
    logic [FPOS_W-1:0] fpos_reg;
    logic [FPOS_W-1:0] fpos_next;
    logic              sync_reg;
    logic              sync_next;

    logic              out_valid_reg;
    byte_t             tx_reg;
    byte_t             tx_next;
    event_t            ev_reg;
    event_t            ev_next;
    byte_t             rd_reg;
    byte_t             rd_next;

    frame_t            shifted;
    logic              code_ok;
    byte_t             rx_sum;
    byte_t             staged_sum;

    assign q_pop    = !q_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, rd_reg, sync_reg, ev_reg, tx_reg};

    // window after shifting in the new byte, its code check and payload sum
    always_comb
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
            shifted[i] = window_reg[i + 1];
        shifted[FRAME_LEN - 1] = head_item.rx_byte;
        code_ok = 1'b1;
        for (int k = 0; k < CODE_LEN; k++)
            if (shifted[k] != code_byte(k))
                code_ok = 1'b0;
        rx_sum     = '0;
        staged_sum = '0;
        for (int k = CODE_LEN; k < FRAME_LEN - 1; k++)
        begin
            rx_sum     = rx_sum + shifted[k];
            staged_sum = staged_sum + staged_reg[k];
        end
    end

    always_comb
    begin
        window_next  = window_reg;
        active_next  = active_reg;
        staged_next  = staged_reg;
        latched_next = latched_reg;
        fpos_next    = fpos_reg;
        sync_next    = sync_reg;
        tx_next      = '0;
        ev_next      = EV_NONE;
        rd_next      = '0;
        case (head_item.op)
            OP_EXCHANGE:
            begin
                window_next = shifted;
                tx_next     = sync_reg ? active_reg[fpos_reg] : fill_reg;
                if (!sync_reg)
                begin
                    if (code_ok)
                    begin
                        fpos_next = '0;
                        sync_next = 1'b1;
                        ev_next   = EV_SYNCED;
                    end
                end
                else if (int'(fpos_reg) >= FRAME_LEN - 1)
                begin
                    fpos_next = '0;
                    if (!code_ok)
                    begin
                        sync_next = 1'b0;
                        ev_next   = EV_CODE_ERR;
                    end
                    else if (rx_sum != shifted[FRAME_LEN - 1])
                    begin
                        sync_next = 1'b0;
                        ev_next   = EV_SUM_ERR;
                    end
                    else
                    begin
                        latched_next = shifted;
                        staged_next[FRAME_LEN - 1] = staged_sum;
                        active_next  = staged_reg;
                        active_next[FRAME_LEN - 1] = staged_sum;
                        ev_next      = EV_ACCEPTED;
                    end
                end
                else
                    fpos_next = fpos_reg + 1'b1;
            end
            OP_WRITE:
                staged_next[head_item.byte_position] = head_item.payload_value;
            OP_READ:
                rd_next = latched_reg[head_item.byte_position];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= FILL_RESET;
            fpos_reg      <= '0;
            sync_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                window_reg[i]  <= '0;
                active_reg[i]  <= (i < CODE_LEN) ? code_byte(i) : 8'd0;
                staged_reg[i]  <= (i < CODE_LEN) ? code_byte(i) : 8'd0;
                latched_reg[i] <= (i == SERVO_SLOT) ? SERVO_RESET : 8'd0;
            end
        end
        else
        begin
            if (cfg_valid)
                fill_reg <= cfg_data;
            if (q_pop)
            begin
                window_reg  <= window_next;
                active_reg  <= active_next;
                staged_reg  <= staged_next;
                latched_reg <= latched_next;
                fpos_reg    <= fpos_next;
                sync_reg    <= sync_next;
            end
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tx_reg <= tx_next;
            ev_reg <= ev_next;
            rd_reg <= rd_next;
        end
    end

endmodule

`default_nettype wire

[hdl/spi_slave_frame_sync_exchange_top.sv]
// SPI slave frame sync exchange, top level: front end, item queue, back end.
// Uses spisfx_pkg, spisfx_front, spisfx_queue, spisfx_back.
//
// Usage:
//   s_* carries one command per transfer: tuser = command (exchange, write
//   staged payload byte, read latched byte); tdata = rx_byte, byte_position,
//   payload_value from the low bit up.
//   m_* returns exactly one result per command: tdata = tx_byte, frame_event,
//   link_synced, read_data from the low bit up.
//   cfg_* writes the idle fill byte; cfg_ready is always high. Write only
//   while no command is in flight.
// Timing:
//   The result passes through the queue slot, then the back-end output
//   register, before its result transfer. One command per cycle is sustained
//   while m_tready stays high; the back end computes each command, frame
//   check and checksums included, combinationally into its output register.
// Reset:
//   Asynchronous, active low. Link out of sync, window cleared, both outgoing
//   frames hold the sync code then zeros, latched frame zero but the servo
//   byte, fill byte 0xBE.
// Stall:
//   If m_tready is low the result holds; the two-entry queue keeps taking
//   input until full, then s_tready drops.
`default_nettype none

module spi_slave_frame_sync_exchange_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], byte_position[10:8], payload_value[18:11]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // tx_byte[7:0], frame_event[10:8], link_synced[11],
                                        // read_data[19:12]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // idle_fill_byte
);
    import spisfx_pkg::*;

    item_t push_item;
    item_t head_item;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;

    spisfx_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    spisfx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (head_item),
        .empty     (q_empty)
    );

    spisfx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .head_item (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[bench/spisfx_checker.sv]
// Checker for the SPI slave frame sync exchange block: watches the command, result
// and fill byte channels, keeps its own copy of the link state and compares each result.
// Depends on spisfx_pkg.
module spisfx_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], byte_position[10:8], payload_value[18:11]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // tx_byte[7:0], frame_event[10:8], link_synced[11],
                                        // read_data[19:12]
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,  // idle_fill_byte
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spisfx_pkg::*;

    typedef logic [FRAME_LEN-1:0][7:0] frame_vec_t;

    typedef struct packed {
        byte_t  tx;
        event_t ev;
        logic   synced;
        byte_t  rd;
    } reply_t;

    frame_vec_t  shift_win;
    frame_vec_t  tx_live;
    frame_vec_t  tx_next;
    frame_vec_t  rx_kept;
    int unsigned slot;
    logic        locked;
    byte_t       fill_byte;

    reply_t      reply_q[$];
    int          fail_cnt = 0;
    int          pending_r = 0;

    assign errors  = fail_cnt;
    assign pending = pending_r;

    function automatic logic code_ok(input frame_vec_t f);
        return f[0] == CODE_R && f[1] == CODE_O && f[2] == CODE_B;
    endfunction

    // mod-256 sum over the payload bytes, code and checksum bytes excluded
    function automatic byte_t sum_of_payload(input frame_vec_t f);
        byte_t s;
        s = 8'd0;
        for (int k = CODE_LEN; k < FRAME_LEN - 1; k++)
            s += f[k];
        return s;
    endfunction

    task automatic reset_link();
        shift_win = '0;
        tx_next   = '0;
        tx_next[0] = CODE_R;
        tx_next[1] = CODE_O;
        tx_next[2] = CODE_B;
        tx_live   = tx_next;
        tx_live[FRAME_LEN-1] = sum_of_payload(tx_live);
        rx_kept   = '0;
        rx_kept[SERVO_SLOT] = SERVO_RESET;
        slot      = 0;
        locked    = 1'b0;
        fill_byte = FILL_RESET;
    endtask

    task automatic link_step(input logic [1:0] cmd, input byte_t rx, input logic [2:0] pos,
                             input byte_t val, output reply_t r);
        r = '0;
        case (cmd)
            CMD_EXCHANGE:
            begin
                shift_win = {rx, shift_win[FRAME_LEN-1:1]};
                r.tx = (locked && slot < FRAME_LEN) ? tx_live[slot] : fill_byte;
                if (!locked)
                begin
                    if (code_ok(shift_win))
                    begin
                        slot   = 0;
                        locked = 1'b1;
                        r.ev   = EV_SYNCED;
                    end
                end
                else if (slot >= FRAME_LEN - 1)
                begin
                    if (!code_ok(shift_win))
                    begin
                        locked = 1'b0;
                        r.ev   = EV_CODE_ERR;
                    end
                    else if (sum_of_payload(shift_win) != shift_win[FRAME_LEN-1])
                    begin
                        locked = 1'b0;
                        r.ev   = EV_SUM_ERR;
                    end
                    else
                    begin
                        rx_kept = shift_win;
                        tx_next[FRAME_LEN-1] = sum_of_payload(tx_next);
                        tx_live = tx_next;
                        r.ev    = EV_ACCEPTED;
                    end
                    slot = 0;
                end
                else
                begin
                    slot++;
                end
            end
            CMD_WRITE:
            begin
                // code bytes and checksum byte are not writable
                if (pos >= CODE_LEN && pos < FRAME_LEN - 1)
                    tx_next[pos] = val;
            end
            CMD_READ:
            begin
                if (pos < FRAME_LEN)
                    r.rd = rx_kept[pos];
            end
            default:
            begin
            end
        endcase
        r.synced = locked;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_cnt++;
            if (fail_cnt <= 40)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            reset_link();
            reply_q.delete();
            pending_r <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fill_byte = cfg_data;
            if (s_tvalid && s_tready)
            begin
                link_step(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[18:11], want);
                reply_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 40)
                        $display("%0t ns: stray result, expected none, actual 0x%0h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = reply_q.pop_front();
                    check_field("tx_byte", 32'(want.tx), 32'(m_tdata[7:0]));
                    check_field("frame_event", 32'(want.ev), 32'(m_tdata[10:8]));
                    check_field("link_synced", 32'(want.synced), 32'(m_tdata[11]));
                    check_field("read_data", 32'(want.rd), 32'(m_tdata[19:12]));
                end
            end
            pending_r <= reply_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
// Testbench top for the SPI slave frame sync exchange block: reset, command and
// frame stimulus, result back-pressure, fill byte writes and the verdict.
// Depends on spisfx_pkg, spi_slave_frame_sync_exchange_top and spisfx_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spisfx_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         LONG_HOLD   = 80;
    localparam int         RAND_ITEMS  = 1850;
    localparam int         PHASES      = 4;

    typedef enum int {
        FLAW_NONE,
        FLAW_CODE,
        FLAW_SUM
    } flaw_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire         cfg_ready;

    int          errors;
    int          pending;

    bit          steady    = 1'b0;
    int          hold_reqs = 0;
    int          n_sent    = 0;
    int          n_clean   = 0;
    int          n_damaged = 0;
    int          n_fill    = 0;

    spi_slave_frame_sync_exchange_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    spisfx_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[spi_slave_frame_sync_exchange_top] ERROR");
        $finish;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic byte_t pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    // called at a rising edge; leaves tvalid high when no gap follows
    task automatic send_item(input logic [1:0] cmd, input byte_t rx, input logic [2:0] pos,
                             input byte_t val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, val, pos, rx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_sent++;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_exchange(input byte_t rx);
        send_item(CMD_EXCHANGE, rx, 3'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
    endtask

    // waits until every command sent has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_fill(input byte_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_fill++;
    endtask

    task automatic send_frame(input flaw_t flaw);
        logic [FRAME_LEN-1:0][7:0] f;
        byte_t                     s;
        f[0] = CODE_R;
        f[1] = CODE_O;
        f[2] = CODE_B;
        s = 8'd0;
        for (int k = CODE_LEN; k < FRAME_LEN - 1; k++)
        begin
            f[k] = pick_payload();
            s += f[k];
        end
        f[FRAME_LEN-1] = s;
        case (flaw)
            FLAW_CODE: f[$urandom_range(0, CODE_LEN - 1)] ^= 8'h01 << $urandom_range(0, 7);
            FLAW_SUM:  f[FRAME_LEN-1] ^= byte_t'($urandom_range(1, 255));
            default:   ;
        endcase
        if (flaw == FLAW_NONE)
            n_clean++;
        else
            n_damaged++;
        for (int k = 0; k < FRAME_LEN; k++)
            send_exchange(f[k]);
    endtask

    task automatic random_chunk();
        int    r;
        int    n;
        int    pick;
        flaw_t flaw;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                flaw = (pick < 80) ? FLAW_NONE : (pick < 90) ? FLAW_CODE : FLAW_SUM;
                send_frame(flaw);
            end
        end
        else if (r < 80)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                if ($urandom_range(0, 1))
                    send_item(CMD_WRITE, byte_t'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), pick_payload());
                else
                    send_item(CMD_READ, byte_t'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), byte_t'($urandom_range(0, 255)));
            end
        end
        else if (r < 93)
        begin
            // noise, sometimes a stray piece of the sync word
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
            begin
                send_exchange(CODE_R);
                send_exchange(CODE_O);
            end
            repeat (n) send_exchange(byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            send_item(CMD_UNKNOWN, byte_t'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                      byte_t'($urandom_range(0, 255)));
        end
    endtask

    // result side back-pressure
    initial
    begin
        int g;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_reqs > holds_done)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (steady)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        byte_t fill_set [PHASES];
        int    target;
        fill_set[0] = 8'h00;
        fill_set[1] = 8'hFF;
        fill_set[2] = byte_t'($urandom_range(0, 255));
        fill_set[3] = byte_t'($urandom_range(0, 255));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset fill byte, local commands at the edges, sync, accept, bad sum
        send_item(CMD_UNKNOWN, 8'hFF, 3'd7, 8'hFF);
        send_item(CMD_READ, 8'h00, 3'(SERVO_SLOT), 8'h00);
        send_item(CMD_WRITE, 8'h00, 3'd0, 8'hFF);
        send_item(CMD_WRITE, 8'hFF, 3'd7, 8'hAA);
        send_item(CMD_WRITE, 8'h00, 3'd3, 8'hFF);
        send_item(CMD_WRITE, 8'hFF, 3'd6, 8'h00);
        send_frame(FLAW_NONE);
        send_frame(FLAW_NONE);
        send_frame(FLAW_SUM);
        send_item(CMD_READ, 8'hFF, 3'd7, 8'hFF);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_fill(fill_set[p]);
            steady <= (p == 2);
            if (p == 1)
            begin
                // sink holds off while frames keep coming, input side backs up
                hold_reqs <= hold_reqs + 1;
                send_frame(FLAW_NONE);
                send_frame(FLAW_NONE);
                send_frame(FLAW_NONE);
            end
            target = n_sent + RAND_ITEMS / PHASES;
            while (n_sent < target)
                random_chunk();
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d commands under %0d fill byte settings,", n_sent, n_fill);
        $display("with %0d clean and %0d damaged frames.", n_clean, n_damaged);
        if (errors == 0)
            $display("[spi_slave_frame_sync_exchange_top] OK");
        else
            $display("[spi_slave_frame_sync_exchange_top] ERROR");
        $finish;
    end

endmodule
